FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the fraction block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/fra_pkg.sv
// Package for the fraction block: payload structs, operation and status codes.
// No dependencies.
`default_nettype none
package fra_pkg;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam int         WIDE = 64;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] num_a;
        logic signed [31:0] den_a;
        logic signed [31:0] num_b;
        logic signed [31:0] den_b;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         status;
    } t_out;

    // Request to the shared bit-serial divider.
    typedef struct packed {
        logic            start;
        logic [WIDE-1:0] dividend;
        logic [WIDE-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [WIDE-1:0] quot;
        logic [WIDE-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

FILE: rtl/fra_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on fra_pkg.
`default_nettype none
module fra_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fra_pkg::t_div_req i_req,
    output fra_pkg::t_div_rsp      o_rsp
);
    localparam int W = fra_pkg::WIDE;
    logic          r_busy;
    logic [6:0]    r_cnt;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_d;
    logic          r_done;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb begin
        shifted = {r_r, r_q[W-1]};
        trial   = shifted - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(W);
                r_q    <= i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                // shift one dividend bit into the remainder; keep it if it fits
                if (!trial[W]) begin
                    r_r <= trial[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= shifted[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;
endmodule
`default_nettype wire

FILE: rtl/fraction_arith_reduce.sv
// Fraction arithmetic with GCD reduction; one transaction at a time.
// The running time grows with the number of Euclid remainder steps, each of
// which uses the shared bit-serial divider, as do the two final divisions.
// A new transaction is taken only when idle; busy stays high until o_valid.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
// The receiver cannot stall: o_valid marks the result for exactly one cycle.
`default_nettype none
module fraction_arith_reduce #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire fra_pkg::t_in i_data,
    output logic              busy,
    output logic              o_valid,
    output fra_pkg::t_out     o_data
);
    localparam int W  = fra_pkg::WIDE;
    localparam int OW = OPERAND_WIDTH;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL1  = 8'b0000_0010,
        S_MUL2  = 8'b0000_0100,
        S_COMB  = 8'b0000_1000,
        S_GCD   = 8'b0001_0000,
        S_DIVN  = 8'b0010_0000,
        S_DIVD  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state            r_state;
    logic [1:0]        r_op;
    logic [OW:0]       r_na, r_da, r_nb, r_db;   // magnitudes
    logic              r_sna, r_sda, r_snb, r_sdb;
    logic [W-1:0]      r_p1, r_p2, r_p3;          // products
    logic [W-1:0]      r_num, r_den, r_x, r_y;
    logic              r_neg;
    logic              r_wait;
    logic [W-1:0]      r_qn;
    logic              r_valid;
    fra_pkg::t_out     r_out;
    fra_pkg::t_div_req div_req;
    fra_pkg::t_div_rsp div_rsp;

    // Take an operand's low OW bits, sign-extended, and return the magnitude.
    function automatic logic [OW:0] mag_of(input logic [31:0] raw);
        logic [OW:0] x;
        x = {raw[OW-1], raw[OW-1:0]};
        return x[OW] ? (~x + 1'b1) : x;
    endfunction

    logic [W-1:0] m_a, m_b;
    logic [W-1:0] sum_mag;
    logic         sum_neg, bneg, sneg1, sneg2;

    always_comb begin
        // product signs follow the operands that formed them
        sneg1   = r_sna ^ r_sdb;
        sneg2   = r_snb ^ r_sda ^ (r_op == fra_pkg::OP_SUB);
        bneg    = sneg2 && (r_p2 != '0);
        if ((sneg1 && (r_p1 != '0)) == bneg) begin
            sum_mag = r_p1 + r_p2;
            sum_neg = bneg;
        end else if (r_p1 >= r_p2) begin
            sum_mag = r_p1 - r_p2;
            sum_neg = sneg1;
        end else begin
            sum_mag = r_p2 - r_p1;
            sum_neg = bneg;
        end
        m_a = W'(r_na);
        m_b = W'(r_db);
        case (r_state)
            S_MUL1:  begin m_a = W'(r_na); m_b = (r_op == fra_pkg::OP_MUL) ? W'(r_nb) : W'(r_db); end
            S_MUL2:  begin m_a = W'(r_da); m_b = (r_op == fra_pkg::OP_DIV) ? W'(r_nb) : W'(r_db); end
            S_COMB:  begin m_a = W'(r_nb); m_b = W'(r_da); end
            default: begin m_a = W'(r_na); m_b = W'(r_db); end
        endcase
    end

    // One multiplier, at most 33x33, reused in S_MUL1, S_MUL2 and S_COMB.
    logic [2*OW+1:0] prod_full;
    logic [W-1:0]    prod;
    assign prod_full = m_a[OW:0] * m_b[OW:0];
    assign prod      = W'(prod_full);

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_x;
        div_req.divisor  = r_y;
        if (!r_wait && (r_state == S_GCD || r_state == S_DIVN || r_state == S_DIVD))
            div_req.start = (r_state != S_GCD) || (r_y != '0);
        if (r_state == S_DIVN) div_req.dividend = r_num;
        if (r_state == S_DIVD) div_req.dividend = r_den;
        if (r_state == S_DIVN || r_state == S_DIVD) div_req.divisor = r_x;
    end

    fra_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        // capture operands as sign and magnitude
                        r_op  <= i_data.operation;
                        r_na  <= mag_of(i_data.num_a);
                        r_da  <= mag_of(i_data.den_a);
                        r_nb  <= mag_of(i_data.num_b);
                        r_db  <= mag_of(i_data.den_b);
                        r_sna <= i_data.num_a[OW-1];
                        r_sda <= i_data.den_a[OW-1];
                        r_snb <= i_data.num_b[OW-1];
                        r_sdb <= i_data.den_b[OW-1];
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_out.res_num <= '0;
                    r_out.res_den <= 63'd1;
                    r_out.status  <= fra_pkg::ST_OK;
                    if (r_da == '0 || r_db == '0) begin
                        r_out.status <= fra_pkg::ST_ZERO_DEN;
                        r_state <= S_OUT;
                    end else if (r_op == fra_pkg::OP_DIV && r_nb == '0) begin
                        r_out.status <= fra_pkg::ST_DIV_ZERO;
                        r_state <= S_OUT;
                    end else begin
                        r_p1 <= prod;
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_p3 <= prod;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    r_den <= r_p3;
                    if (r_op == fra_pkg::OP_ADD || r_op == fra_pkg::OP_SUB) begin
                        // register the second cross product in r_p2 and add it in the following S_COMB pass
                        r_p2 <= prod;
                        r_op <= r_op;
                        r_state <= S_COMB;
                        if (r_wait) begin
                            r_num <= sum_mag;
                            r_neg <= sum_neg ^ (r_sda ^ r_sdb);
                            r_wait <= 1'b0;
                            r_state <= S_GCD;
                            r_x <= sum_mag;
                            r_y <= r_p3;
                            if (sum_mag == '0) r_state <= S_OUT;
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end else begin
                        r_num <= r_p1;
                        r_x   <= r_p1;
                        r_y   <= r_p3;
                        r_neg <= (r_op == fra_pkg::OP_MUL)
                            ? (r_sna ^ r_snb ^ r_sda ^ r_sdb)
                            : (r_sna ^ r_sdb ^ r_sda ^ r_snb);
                        r_state <= (r_p1 == '0) ? S_OUT : S_GCD;
                    end
                end
                S_GCD: begin
                    // Euclid: x, y <- y, x mod y until y is zero
                    if (r_y == '0) begin
                        r_state <= S_DIVN;
                    end else if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_rsp.done) begin
                        r_x <= r_y;
                        r_y <= div_rsp.rem;
                        r_wait <= 1'b0;
                    end
                end
                S_DIVN: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_rsp.done) begin
                        r_qn <= div_rsp.quot;
                        r_wait <= 1'b0;
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (div_rsp.done) begin
                        r_wait <= 1'b0;
                        // saturate magnitude to 2^63-1, then apply the sign
                        r_out.res_num <= r_qn[W-1]
                            ? (r_neg ? {1'b1, {(W-1){1'b0}}} + 64'd1 : {1'b0, {(W-1){1'b1}}})
                            : (r_neg ? (~r_qn + 64'd1) : r_qn);
                        r_out.res_den <= div_rsp.quot[W-2:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_data  = r_out;

`include "assert_macros.svh"
    `ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_IMPL(a_den_pos, i_clk, i_rst_n, o_valid, o_data.res_den != '0)
    `ASSERT_IMPL(a_zero_den1, i_clk, i_rst_n, o_valid && o_data.res_num == '0,
        o_data.res_den == 63'd1)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule
`default_nettype wire
